>>> rtl/lphs_pkg.sv
// Shared types and constants for the linear-probing hash set.
// Slot entry layout, action/status/mark codes. No dependencies.
package lphs_pkg;

    localparam int SLOTS    = 256;
    localparam int KEY_BITS = 32;
    localparam int HASH_W   = 32;
    localparam int SLOT_W   = $clog2(SLOTS);
    localparam int CNT_W    = SLOT_W + 1;

    // Reset value of the load limit register
    localparam logic [CNT_W-1:0] LOAD_LIMIT_RST = CNT_W'(192);

    // Register index of load_limit on the configuration port
    localparam logic REG_LOAD_LIMIT = 1'b0;

    typedef enum logic [1:0] {
        ACT_ADD    = 2'd0,
        ACT_DELETE = 2'd1,
        ACT_TEST   = 2'd2,
        ACT_CLEAR  = 2'd3
    } action_t;

    typedef enum logic [1:0] {
        ST_OK      = 2'd0,
        ST_FULL    = 2'd1,
        ST_NO_SLOT = 2'd2,
        ST_UNUSED  = 2'd3
    } status_t;

    typedef enum logic [1:0] {
        MARK_EMPTY = 2'd0,
        MARK_USED  = 2'd1,
        MARK_TOMB  = 2'd2,
        MARK_RSVD  = 2'd3
    } mark_t;

    typedef struct packed {
        mark_t               mark;
        logic [HASH_W-1:0]   hash;
        logic [KEY_BITS-1:0] key;
    } entry_t;

endpackage

>>> rtl/linear_probe_hash_set.sv
// Linear-probing hash set with tombstones over one synchronous slot memory.
// Depends on lphs_pkg (entry layout, action, status and mark codes).
//
//  channel   | signals                                   | handshake
//  ----------+-------------------------------------------+---------------------------
//  command   | action, key, key_hash                     | beat when start && !busy
//  result    | status, found, slot, live_count           | one-cycle strobe on done
//  config    | psel, penable, pwrite, paddr, pwdata,     | APB, pready tied high,
//            | prdata, pready                            | load_limit at address 0
//
// A clear goes from accept straight to the finish state; any other action first
// probes P slots (1 to 256), one slot per cycle through the single read port of
// the slot memory, then finishes. busy stays high from accept until the cycle in
// which done is shown, so the next beat may be accepted while a result is on the
// ports. Reset clears the per-slot valid bits, the live count and the sequencer
// at once; there is no clearing pass. The receiver cannot stall the result.
module linear_probe_hash_set
(
    input  logic                            clk,
    input  logic                            rst_n,
    // command
    input  logic                            start,
    output logic                            busy,
    input  logic [1:0]                      action,
    input  logic [lphs_pkg::KEY_BITS-1:0]   key,
    input  logic [lphs_pkg::HASH_W-1:0]     key_hash,
    // result
    output logic                            done,
    output logic [1:0]                      status,
    output logic                            found,
    output logic [lphs_pkg::SLOT_W-1:0]     slot,
    output logic [lphs_pkg::CNT_W-1:0]      live_count,
    // configuration
    input  logic                            psel,
    input  logic                            penable,
    input  logic                            pwrite,
    input  logic [2:0]                      paddr,
    input  logic [31:0]                     pwdata,
    output logic [31:0]                     prdata,
    output logic                            pready
);
    import lphs_pkg::*;

    typedef enum logic [2:0] {
        S_IDLE   = 3'b001,
        S_PROBE  = 3'b010,
        S_FINISH = 3'b100
    } state_t;

    state_t                state_reg, state_next;

    // latched command
    action_t               act_reg;
    logic [KEY_BITS-1:0]   key_reg;
    logic [HASH_W-1:0]     hash_reg;

    // probe bookkeeping
    logic [SLOT_W-1:0]     chk_addr_reg;
    logic [SLOT_W-1:0]     chk_cnt_reg;
    logic                  tomb_seen_reg, tomb_seen_next;
    logic [SLOT_W-1:0]     tomb_slot_reg, tomb_slot_next;
    logic                  hit_reg;
    logic                  ok_reg;
    logic [SLOT_W-1:0]     where_reg;

    // set state
    logic [CNT_W-1:0]      entry_cnt_reg, entry_cnt_next;
    logic [CNT_W-1:0]      load_limit_reg;
    logic [SLOTS-1:0]      slot_vld_reg;

    // slot memory
    entry_t                slot_mem [SLOTS];
    entry_t                rd_entry_reg;
    logic                  rd_vld_reg;
    logic [SLOT_W-1:0]     rd_addr;
    logic                  wr_en;
    entry_t                wr_data;

    // result registers
    logic                  done_reg;
    status_t               status_reg, status_next;
    logic                  found_reg, found_next;
    logic [SLOT_W-1:0]     slot_reg, slot_next;

    logic                  accept;
    logic                  cfg_wr;
    mark_t                 cur_mark;
    logic                  cur_match;
    logic                  probe_end;
    logic                  end_hit;
    logic                  end_ok;
    logic [SLOT_W-1:0]     end_where;
    logic                  place;
    logic                  wipe;

    assign accept = start && (state_reg == S_IDLE);
    assign busy   = (state_reg != S_IDLE);
    assign cfg_wr = psel && penable && pwrite && pready;
    assign pready = 1'b1;

    // register read-back
    always_comb
    begin
        prdata = '0;
        if (paddr[2] == REG_LOAD_LIMIT)
        begin
            prdata = 32'(load_limit_reg);
        end
    end

    // read the home slot on accept, then the next slot every probe cycle
    assign rd_addr = (state_reg == S_IDLE) ? key_hash[SLOT_W-1:0]
                                            : chk_addr_reg + SLOT_W'(1);

    // classify the slot whose data arrived this cycle
    assign cur_mark  = rd_vld_reg ? rd_entry_reg.mark : MARK_EMPTY;
    assign cur_match = (cur_mark == MARK_USED) && (rd_entry_reg.hash == hash_reg)
                       && (rd_entry_reg.key == key_reg);

    always_comb
    begin
        tomb_seen_next = tomb_seen_reg;
        tomb_slot_next = tomb_slot_reg;
        probe_end      = 1'b0;
        end_hit        = 1'b0;
        end_ok         = 1'b0;
        end_where      = tomb_slot_reg;
        priority if (cur_match)
        begin
            probe_end = 1'b1;
            end_hit   = 1'b1;
            end_ok    = 1'b1;
            end_where = chk_addr_reg;
        end
        else if (cur_mark == MARK_EMPTY)
        begin
            probe_end = 1'b1;
            end_ok    = 1'b1;
            end_where = tomb_seen_reg ? tomb_slot_reg : chk_addr_reg;
        end
        else
        begin
            if ((cur_mark == MARK_TOMB) && !tomb_seen_reg)
            begin
                tomb_seen_next = 1'b1;
                tomb_slot_next = chk_addr_reg;
            end
            // whole table visited: fall back to the first tombstone
            if (&chk_cnt_reg)
            begin
                probe_end = 1'b1;
                end_ok    = tomb_seen_next;
                end_where = tomb_slot_next;
            end
        end
    end

    // resolve the action once probing ends
    always_comb
    begin
        status_next    = ST_OK;
        found_next     = 1'b0;
        slot_next      = '0;
        entry_cnt_next = entry_cnt_reg;
        wr_en          = 1'b0;
        wr_data        = '{mark: MARK_USED, hash: hash_reg, key: key_reg};
        place          = 1'b0;
        wipe           = 1'b0;
        if (state_reg == S_FINISH)
        begin
            if (act_reg == ACT_CLEAR)
            begin
                wipe           = 1'b1;
                entry_cnt_next = '0;
            end
            else if (!ok_reg)
            begin
                status_next = ST_NO_SLOT;
            end
            else if (hit_reg)
            begin
                found_next = 1'b1;
                slot_next  = where_reg;
                if (act_reg == ACT_DELETE)
                begin
                    wr_en          = 1'b1;
                    wr_data        = '{mark: MARK_TOMB, hash: '0, key: '0};
                    entry_cnt_next = entry_cnt_reg - CNT_W'(1);
                end
            end
            else if (act_reg == ACT_ADD)
            begin
                if (entry_cnt_reg >= load_limit_reg)
                begin
                    status_next = ST_FULL;
                end
                else
                begin
                    wr_en          = 1'b1;
                    place          = 1'b1;
                    slot_next      = where_reg;
                    entry_cnt_next = entry_cnt_reg + CNT_W'(1);
                end
            end
        end
    end

    // sequencer
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    state_next = (action_t'(action) == ACT_CLEAR) ? S_FINISH : S_PROBE;
                end
            end
            S_PROBE:
            begin
                if (probe_end)
                begin
                    state_next = S_FINISH;
                end
            end
            S_FINISH:
            begin
                state_next = S_IDLE;
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= S_IDLE;
            entry_cnt_reg  <= '0;
            load_limit_reg <= LOAD_LIMIT_RST;
            slot_vld_reg   <= '0;
            done_reg       <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            entry_cnt_reg <= entry_cnt_next;
            done_reg      <= (state_reg == S_FINISH);
            if (cfg_wr && (paddr[2] == REG_LOAD_LIMIT))
            begin
                load_limit_reg <= pwdata[CNT_W-1:0];
            end
            // drop all slots on clear, mark a slot live once written
            if (wipe)
            begin
                slot_vld_reg <= '0;
            end
            else if (place)
            begin
                slot_vld_reg[where_reg] <= 1'b1;
            end
        end
    end

    // latch the command and track the probe
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            act_reg       <= action_t'(action);
            key_reg       <= key;
            hash_reg      <= key_hash;
            chk_addr_reg  <= key_hash[SLOT_W-1:0];
            chk_cnt_reg   <= '0;
            tomb_seen_reg <= 1'b0;
            tomb_slot_reg <= '0;
        end
        else if (state_reg == S_PROBE)
        begin
            chk_addr_reg  <= chk_addr_reg + SLOT_W'(1);
            chk_cnt_reg   <= chk_cnt_reg + SLOT_W'(1);
            tomb_seen_reg <= tomb_seen_next;
            tomb_slot_reg <= tomb_slot_next;
            hit_reg       <= end_hit;
            ok_reg        <= end_ok;
            where_reg     <= end_where;
        end
    end

    // slot memory: one write port, one registered read port
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            slot_mem[where_reg] <= wr_data;
        end
        rd_entry_reg <= slot_mem[rd_addr];
        rd_vld_reg   <= slot_vld_reg[rd_addr];
    end

    // hold the result for its strobe cycle
    always_ff @(posedge clk)
    begin
        if (state_reg == S_FINISH)
        begin
            status_reg <= status_next;
            found_reg  <= found_next;
            slot_reg   <= slot_next;
        end
    end

    assign done       = done_reg;
    assign status     = status_reg;
    assign found      = found_reg;
    assign slot       = slot_reg;
    assign live_count = entry_cnt_reg;

endmodule

>>> dv/tb_linear_probe_hash_set.sv
// Self-checking testbench for linear_probe_hash_set: add, delete, test and clear
// commands checked against a shadow hash set kept in the bench. Needs lphs_pkg.
// Covers load limit settings, table-full cases and random command traffic.
module tb_linear_probe_hash_set;
    timeunit 1ns;
    timeprecision 1ps;

    import lphs_pkg::*;

    localparam int POOL_SIZE = 40;

    typedef struct packed {
        status_t              status;
        logic                 found;
        logic [SLOT_W-1:0]    slot;
        logic [CNT_W-1:0]     live_count;
    } set_reply_t;

    logic                  clk = 1'b0;
    logic                  rst_n;
    logic                  start;
    logic                  busy;
    logic [1:0]            action;
    logic [KEY_BITS-1:0]   key;
    logic [HASH_W-1:0]     key_hash;
    logic                  done;
    logic [1:0]            status;
    logic                  found;
    logic [SLOT_W-1:0]     slot;
    logic [CNT_W-1:0]      live_count;
    logic                  psel;
    logic                  penable;
    logic                  pwrite;
    logic [2:0]            paddr;
    logic [31:0]           pwdata;
    logic [31:0]           prdata;
    logic                  pready;

    // Shadow copy of the set and its load limit
    mark_t                 shadow_mark [SLOTS];
    logic [KEY_BITS-1:0]   shadow_key  [SLOTS];
    logic [HASH_W-1:0]     shadow_hash [SLOTS];
    logic [CNT_W-1:0]      shadow_live;
    logic [CNT_W-1:0]      shadow_tombs;
    logic [CNT_W-1:0]      shadow_limit;

    set_reply_t            pending_replies [$];
    int                    mismatches = 0;
    int                    gap_pct = 0;
    int                    cmd_count = 0;
    int                    hit_count = 0;
    int                    full_count = 0;
    int                    no_slot_count = 0;

    linear_probe_hash_set uut
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .start      (start),
        .busy       (busy),
        .action     (action),
        .key        (key),
        .key_hash   (key_hash),
        .done       (done),
        .status     (status),
        .found      (found),
        .slot       (slot),
        .live_count (live_count),
        .psel       (psel),
        .penable    (penable),
        .pwrite     (pwrite),
        .paddr      (paddr),
        .pwdata     (pwdata),
        .prdata     (prdata),
        .pready     (pready)
    );

    always #2 clk = ~clk;

    // Run one command on the shadow set and return the reply it should give
    function automatic set_reply_t apply_command(action_t act, logic [KEY_BITS-1:0] k,
                                                 logic [HASH_W-1:0] h);
        set_reply_t        r;
        logic [SLOT_W-1:0] cur;
        logic [SLOT_W-1:0] tomb;
        logic [SLOT_W-1:0] where;
        logic              have_tomb;
        logic              hit;
        logic              ok;
        r = '{status: ST_OK, found: 1'b0, slot: '0, live_count: '0};
        cur = h[SLOT_W-1:0];
        tomb = '0;
        where = '0;
        have_tomb = 1'b0;
        hit = 1'b0;
        ok = 1'b0;
        cmd_count++;
        if (act == ACT_CLEAR)
        begin
            for (int i = 0; i < SLOTS; i++)
                shadow_mark[i] = MARK_EMPTY;
            shadow_live = '0;
            shadow_tombs = '0;
        end
        else
        begin
            // Walk from the home slot; stop on a match or an empty slot
            for (int n = 0; n < SLOTS && !ok; n++)
            begin
                if (shadow_mark[cur] == MARK_USED)
                begin
                    if (shadow_hash[cur] == h && shadow_key[cur] == k)
                    begin
                        hit = 1'b1;
                        ok = 1'b1;
                        where = cur;
                    end
                end
                else if (shadow_mark[cur] == MARK_TOMB)
                begin
                    if (!have_tomb)
                    begin
                        have_tomb = 1'b1;
                        tomb = cur;
                    end
                end
                else
                begin
                    ok = 1'b1;
                    where = have_tomb ? tomb : cur;
                end
                cur = cur + SLOT_W'(1);
            end
            // A full walk with no empty slot may still reuse a tombstone
            if (!ok)
            begin
                ok = have_tomb;
                where = tomb;
            end
            r.found = hit;
            if (!ok)
            begin
                r.status = ST_NO_SLOT;
                no_slot_count++;
            end
            else if (hit)
            begin
                r.slot = where;
                hit_count++;
                if (act == ACT_DELETE)
                begin
                    shadow_mark[where] = MARK_TOMB;
                    shadow_live = shadow_live - CNT_W'(1);
                    shadow_tombs = shadow_tombs + CNT_W'(1);
                end
            end
            else if (act == ACT_ADD)
            begin
                if (shadow_live >= shadow_limit)
                begin
                    r.status = ST_FULL;
                    full_count++;
                end
                else
                begin
                    if (shadow_mark[where] == MARK_TOMB && shadow_tombs != 0)
                        shadow_tombs = shadow_tombs - CNT_W'(1);
                    shadow_mark[where] = MARK_USED;
                    shadow_key[where] = k;
                    shadow_hash[where] = h;
                    shadow_live = shadow_live + CNT_W'(1);
                    r.slot = where;
                end
            end
        end
        r.live_count = shadow_live;
        return r;
    endfunction

    task automatic note_mismatch(string msg);
        mismatches++;
        if (mismatches <= 10)
            $display("%0t ns mismatch: %s", $time, msg);
    endtask

    // Send one command beat; called and returns at a falling edge, start left high
    task automatic issue_command(action_t act, logic [KEY_BITS-1:0] k, logic [HASH_W-1:0] h);
        logic accepted;
        accepted = 1'b0;
        while ($urandom_range(99) < gap_pct)
        begin
            start = 1'b0;
            @(negedge clk);
        end
        start = 1'b1;
        action = act;
        key = k;
        key_hash = h;
        while (!accepted)
        begin
            @(posedge clk);
            if (!busy)
                accepted = 1'b1;
        end
        pending_replies.push_back(apply_command(act, k, h));
        @(negedge clk);
    endtask

    // Drop start and wait until every reply is back
    task automatic settle_quiet();
        start = 1'b0;
        while (pending_replies.size() != 0)
            @(negedge clk);
        repeat (4) @(negedge clk);
    endtask

    task automatic read_load_limit(logic [CNT_W-1:0] want);
        psel = 1'b1;
        pwrite = 1'b0;
        penable = 1'b0;
        paddr = 3'(4 * int'(REG_LOAD_LIMIT));
        @(negedge clk);
        penable = 1'b1;
        do
            @(posedge clk);
        while (!pready);
        if (prdata !== 32'(want))
            note_mismatch($sformatf("load_limit read %0d, expected %0d", prdata, want));
        @(negedge clk);
        psel = 1'b0;
        penable = 1'b0;
    endtask

    // Write the load limit with the set idle, then read it back
    task automatic write_load_limit(logic [CNT_W-1:0] value);
        settle_quiet();
        psel = 1'b1;
        pwrite = 1'b1;
        penable = 1'b0;
        paddr = 3'(4 * int'(REG_LOAD_LIMIT));
        pwdata = 32'(value);
        @(negedge clk);
        penable = 1'b1;
        do
            @(posedge clk);
        while (!pready);
        shadow_limit = value;
        @(negedge clk);
        psel = 1'b0;
        penable = 1'b0;
        pwrite = 1'b0;
        @(negedge clk);
        read_load_limit(shadow_limit);
    endtask

    // Check every result beat against the oldest pending reply
    always @(posedge clk)
    begin
        set_reply_t want;
        if (rst_n === 1'b1 && done === 1'b1)
        begin
            if (pending_replies.size() == 0)
                note_mismatch("result beat with no command pending");
            else
            begin
                want = pending_replies.pop_front();
                if (status !== want.status || found !== want.found
                    || slot !== want.slot || live_count !== want.live_count)
                    note_mismatch($sformatf(
                        "status %0d/%0d found %0d/%0d slot %0d/%0d count %0d/%0d (exp/got)",
                        want.status, status, want.found, found, want.slot, slot,
                        want.live_count, live_count));
            end
        end
    end

    // Collisions, wrap, tombstone reuse, key vs hash compare, clear
    task automatic test_basic_ops();
        gap_pct = 9;
        read_load_limit(LOAD_LIMIT_RST);
        issue_command(ACT_TEST, 32'h0, 32'h0);
        issue_command(ACT_ADD, 32'h0, 32'h0);
        issue_command(ACT_ADD, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
        issue_command(ACT_ADD, 32'h5, 32'h0000_0100);
        issue_command(ACT_ADD, 32'h0, 32'h0);
        issue_command(ACT_TEST, 32'h0, 32'h0000_0100);
        issue_command(ACT_DELETE, 32'h0, 32'h0);
        issue_command(ACT_TEST, 32'h5, 32'h0000_0100);
        issue_command(ACT_ADD, 32'h7, 32'h0000_0200);
        issue_command(ACT_DELETE, 32'hDEAD_BEEF, 32'h0000_0003);
        issue_command(ACT_ADD, 32'h9, 32'h0000_00FF);
        issue_command(ACT_TEST, 32'h9, 32'h0000_00FF);
        issue_command(ACT_DELETE, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
        issue_command(ACT_CLEAR, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
        issue_command(ACT_TEST, 32'h5, 32'h0000_0100);
    endtask

    // Limit of zero, limit of one, add of a present key at the limit
    task automatic test_load_limit();
        gap_pct = 9;
        write_load_limit(9'd0);
        issue_command(ACT_ADD, 32'h1234_5678, 32'h0000_0010);
        issue_command(ACT_TEST, 32'h1234_5678, 32'h0000_0010);
        write_load_limit(9'd1);
        issue_command(ACT_ADD, 32'h1234_5678, 32'h0000_0010);
        issue_command(ACT_ADD, 32'h8765_4321, 32'h0000_0011);
        issue_command(ACT_ADD, 32'h1234_5678, 32'h0000_0010);
        issue_command(ACT_DELETE, 32'h1234_5678, 32'h0000_0010);
        issue_command(ACT_ADD, 32'h8765_4321, 32'h0000_0011);
        issue_command(ACT_CLEAR, 32'h0, 32'h0);
    endtask

    // Fill every slot with a limit above the table size, then probe the full table
    task automatic test_full_table();
        logic [KEY_BITS-1:0] fill_key  [SLOTS];
        logic [HASH_W-1:0]   fill_hash [SLOTS];
        logic [KEY_BITS-1:0] outsider;
        logic [HASH_W-1:0]   outsider_hash;
        gap_pct = 9;
        write_load_limit(9'd511);
        outsider = $urandom;
        outsider_hash = {24'($urandom), 8'h80};
        for (int i = 0; i < SLOTS; i++)
        begin
            fill_key[i] = $urandom;
            fill_hash[i] = {24'($urandom), 8'(i)};
            issue_command(ACT_ADD, fill_key[i], fill_hash[i]);
        end
        issue_command(ACT_ADD, outsider, outsider_hash);
        issue_command(ACT_TEST, outsider, outsider_hash);
        issue_command(ACT_DELETE, outsider, outsider_hash);
        issue_command(ACT_ADD, fill_key[37], fill_hash[37]);
        issue_command(ACT_DELETE, fill_key[200], fill_hash[200]);
        issue_command(ACT_TEST, outsider, outsider_hash);
        issue_command(ACT_ADD, outsider, outsider_hash);
        write_load_limit(9'd256);
        issue_command(ACT_ADD, ~outsider, outsider_hash);
        issue_command(ACT_DELETE, fill_key[5], fill_hash[5]);
        issue_command(ACT_ADD, ~outsider, outsider_hash);
        issue_command(ACT_ADD, fill_key[5], fill_hash[5]);
        issue_command(ACT_CLEAR, 32'h0, 32'h0);
    endtask

    // Random traffic over a small pool of keys, half of them on clustered home slots
    task automatic test_random_traffic(int idle_pct, logic [CNT_W-1:0] limit_val, int count);
        logic [KEY_BITS-1:0] pool_key  [POOL_SIZE];
        logic [HASH_W-1:0]   pool_hash [POOL_SIZE];
        int                  roll;
        int                  pick;
        write_load_limit(limit_val);
        gap_pct = idle_pct;
        for (int i = 0; i < POOL_SIZE; i++)
        begin
            // Some entries share a key with their neighbor but hash differently
            pool_key[i] = (i % 4 == 1) ? pool_key[i-1] : $urandom;
            pool_hash[i] = $urandom;
            if (i % 2 == 0)
                pool_hash[i][7:0] = 8'(240 + $urandom_range(0, 31));
        end
        for (int n = 0; n < count; n++)
        begin
            roll = $urandom_range(99);
            pick = $urandom_range(POOL_SIZE - 1);
            if (roll < 2)
                issue_command(ACT_CLEAR, $urandom, $urandom);
            else if (roll < 45)
                issue_command(ACT_ADD, pool_key[pick], pool_hash[pick]);
            else if (roll < 65)
                issue_command(ACT_DELETE, pool_key[pick], pool_hash[pick]);
            else if (roll < 92)
                issue_command(ACT_TEST, pool_key[pick], pool_hash[pick]);
            else
                issue_command(action_t'($urandom_range(2)), $urandom, $urandom);
        end
    endtask

    initial
    begin
        rst_n = 1'b0;
        start = 1'b0;
        action = ACT_TEST;
        key = '0;
        key_hash = '0;
        psel = 1'b0;
        penable = 1'b0;
        pwrite = 1'b0;
        paddr = '0;
        pwdata = '0;
        for (int i = 0; i < SLOTS; i++)
        begin
            shadow_mark[i] = MARK_EMPTY;
            shadow_key[i] = '0;
            shadow_hash[i] = '0;
        end
        shadow_live = '0;
        shadow_tombs = '0;
        shadow_limit = LOAD_LIMIT_RST;
        repeat (7) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);

        test_basic_ops();
        test_load_limit();
        test_full_table();
        test_random_traffic(9, 9'd256, 260);
        test_random_traffic(82, 9'($urandom_range(2, 12)), 260);
        test_random_traffic(0, 9'($urandom_range(1, 256)), 260);

        // Let any stray result beat show up before judging
        settle_quiet();
        repeat (300) @(negedge clk);
        if (pending_replies.size() != 0)
            note_mismatch("replies still pending at end of run");

        $display("Ran %0d commands: %0d key hits, %0d refused at the load limit, %0d with no slot",
                 cmd_count, hit_count, full_count, no_slot_count);
        $display("Load limits 0, 1, 192, 256, 511 and random ones; %0d mismatches", mismatches);
        if (mismatches == 0)
            $display("linear_probe_hash_set test passed");
        else
            $display("linear_probe_hash_set test failed");
        $finish;
    end

    // Watchdog: far beyond the slowest legal run
    initial
    begin
        #10_000_000;
        $display("Timed out with %0d replies pending", pending_replies.size());
        $display("linear_probe_hash_set test failed");
        $finish;
    end

endmodule
